// ===== rtl/quadtree_patch_index_map_unit_defines.svh =====
// Assertion macros shared by the quadtree patch index map RTL.
`ifndef QUADTREE_PATCH_INDEX_MAP_UNIT_DEFINES_SVH
`define QUADTREE_PATCH_INDEX_MAP_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define QPIM_ASSERT_IMPLY(name, clk_sig, rstn_sig, ante, cons, msg) \
	name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define QPIM_ASSERT_NEXT(name, clk_sig, rstn_sig, ante, cons, msg) \
	name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/qpim_pkg.sv =====
// Types, widths, codes and helpers of the quadtree patch index map.
package qpim_pkg;

	localparam int LVL_W      = 4;
	localparam int LOG_W      = 4;
	localparam int CNT_W      = 5;
	localparam int IDX_W      = 24;
	localparam int XZ_W       = 11;
	localparam int Q_W        = 2;
	localparam int LNI_W      = 26;
	localparam int SUM_W      = 29;
	localparam int ORG_W      = 12;
	localparam int RGN_W      = 13;
	localparam int GRID_W     = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [IDX_W-1:0]      SAT24            = '1;
	localparam logic [LOG_W-1:0]      RST_TILE_LOG2    = 4'd6;
	localparam logic [CFG_DATA_W-1:0] RST_PATCH_QUADS  = 16'd16;
	localparam logic [LVL_W-1:0]      RST_LEVEL_LIMIT  = 4'd12;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TILE_LOG2   = 2'd0,
		CFG_PATCH_QUADS = 2'd1,
		CFG_LEVEL_LIMIT = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		REQ_DECODE = 1'b0,
		REQ_ENCODE = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		DRV_IDLE,
		DRV_INIT,
		DRV_RUN
	} drv_state_t;

	typedef struct packed {
		req_t             req;
		logic [IDX_W-1:0] idx;
		logic [LVL_W-1:0] lvl;
		logic [XZ_W-1:0]  x;
		logic [XZ_W-1:0]  z;
		logic [Q_W-1:0]   q;
		logic             err;
	} s1_t;

	typedef struct packed {
		req_t             req;
		logic [IDX_W-1:0] idx;
		logic [LVL_W-1:0] lvl;
		logic [XZ_W-1:0]  x;
		logic [XZ_W-1:0]  z;
		logic [Q_W-1:0]   q;
		logic [LNI_W-1:0] lni;
		logic [IDX_W-1:0] noff;
		logic [IDX_W-1:0] poff;
		logic             hc;
		logic [LOG_W-1:0] gl;
		logic             err;
	} s2_t;

	typedef struct packed {
		logic             error;
		logic [LVL_W-1:0] node_level;
		logic [XZ_W-1:0]  node_x;
		logic [XZ_W-1:0]  node_z;
		logic [Q_W-1:0]   quadrant;
		logic [IDX_W-1:0] node_index;
		logic [IDX_W-1:0] patch_index;
		logic [ORG_W-1:0] origin_x;
		logic [ORG_W-1:0] origin_z;
		logic [RGN_W-1:0] region_quads;
	} rsp_t;

	// log2 of quads spanned by a node of the given level
	function automatic logic [LOG_W-1:0] grid_log(input logic [LOG_W-1:0] plog,
			input logic [LOG_W-1:0] tlog, input logic [LVL_W-1:0] lvl);
		logic [LOG_W:0] g;
		g = {1'b0, plog} + {1'b0, lvl};
		grid_log = (g < {1'b0, tlog}) ? g[LOG_W-1:0] : tlog;
	endfunction

	// level splits its nodes into four quadrant patches
	function automatic logic has_children(input logic [LOG_W-1:0] plog,
			input logic [LOG_W-1:0] tlog, input logic [LVL_W-1:0] lvl);
		logic [LOG_W:0] g;
		g = {1'b0, plog} + {1'b0, lvl};
		has_children = (lvl != '0) && (g <= {1'b0, tlog});
	endfunction

endpackage

// ===== rtl/quadtree_patch_index_map_unit.sv =====
// Quadtree patch index map: converts linear patch indices to node keys and back.
//
// Channels: the request channel (req_valid / req_stall) carries req_type,
// index_in and the node key; the response channel (rsp_valid / rsp_stall)
// returns one result per request. An item moves at a clock edge where valid
// is high and stall is low. Registers are written through cfg_we, cfg_index and
// cfg_data, one per edge; the user must write them only while no item is in flight (not enforced).
// Throughput: one item per cycle while req_stall is low. The result reaches the
// output register through three register stages: level search, table read and
// unpack or pack, index sums and region.
// Layout tables: after reset and after each register write the level offset
// tables are rebuilt by a sweep of one level per cycle, an init step and then
// one step for each of the MAX_LEVELS levels, while req_stall stays high.
// Stall: when rsp_stall holds a result, the stages behind it keep filling
// until every stage is occupied, then req_stall rises; nothing is dropped.
// Reset: arst_n clears valid bits and registers to tile log2 6, patch size 16
// and level limit 12, then starts the table sweep.
`include "quadtree_patch_index_map_unit_defines.svh"

module quadtree_patch_index_map_unit #(
	parameter int MAX_TILE_LOG2 = 12,
	parameter int MAX_LEVELS    = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [qpim_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [qpim_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic                               req_type,
	input  logic [qpim_pkg::IDX_W-1:0]         index_in,
	input  logic [qpim_pkg::LVL_W-1:0]         key_level,
	input  logic [qpim_pkg::XZ_W-1:0]          key_x,
	input  logic [qpim_pkg::XZ_W-1:0]          key_z,
	input  logic [qpim_pkg::Q_W-1:0]           key_quadrant,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic                               error,
	output logic [qpim_pkg::LVL_W-1:0]         node_level,
	output logic [qpim_pkg::XZ_W-1:0]          node_x,
	output logic [qpim_pkg::XZ_W-1:0]          node_z,
	output logic [qpim_pkg::Q_W-1:0]           quadrant,
	output logic [qpim_pkg::IDX_W-1:0]         node_index,
	output logic [qpim_pkg::IDX_W-1:0]         patch_index,
	output logic [qpim_pkg::ORG_W-1:0]         origin_x,
	output logic [qpim_pkg::ORG_W-1:0]         origin_z,
	output logic [qpim_pkg::RGN_W-1:0]         region_quads
);

	localparam int IDX_W   = qpim_pkg::IDX_W;
	localparam int LVL_W   = qpim_pkg::LVL_W;
	localparam int LOG_W   = qpim_pkg::LOG_W;
	localparam int CNT_W   = qpim_pkg::CNT_W;
	localparam int XZ_W    = qpim_pkg::XZ_W;
	localparam int LNI_W   = qpim_pkg::LNI_W;
	localparam int SUM_W   = qpim_pkg::SUM_W;
	localparam int ORG_W   = qpim_pkg::ORG_W;
	localparam int RGN_W   = qpim_pkg::RGN_W;
	localparam int GRID_W  = qpim_pkg::GRID_W;
	localparam int PQ_W    = qpim_pkg::CFG_DATA_W;
	localparam int ACC_RAW = 2 * MAX_TILE_LOG2 + 3 + $clog2(MAX_LEVELS + 1);
	localparam int ACC_W   = (ACC_RAW > IDX_W) ? ACC_RAW : IDX_W + 1;

	// configuration registers
	logic [LOG_W-1:0] tile_log2_q;
	logic [PQ_W-1:0]  patch_quads_q;
	logic [LVL_W-1:0] level_limit_q;
	logic             cfg_hit;

	// derived layout
	logic [LOG_W-1:0] tlog_q, plog_q;
	logic [CNT_W-1:0] lcnt_q;
	logic [IDX_W-1:0] ptot_q;
	logic [IDX_W-1:0] noff_tab_q [MAX_LEVELS];
	logic [IDX_W-1:0] poff_tab_q [MAX_LEVELS];

	logic [LOG_W-1:0] tlog_c, plog_c;
	logic [PQ_W-1:0]  pq_c;
	logic [CNT_W-1:0] lim_c, lcnt_c;

	// table sweep
	qpim_pkg::drv_state_t state_q, state_nxt;
	logic             busy, init_en, run_en, sweep_last;
	logic [LVL_W-1:0] sweep_q;
	logic [ACC_W-1:0] noff_acc_q, poff_acc_q, noff_nxt, poff_nxt;
	logic [ACC_W-1:0] sw_cnt, sw_pcnt;
	logic [LOG_W-1:0] sw_gl, sw_s;
	logic             sw_hc, sw_act;

	// pipeline
	logic             v_s1, v_s2, v_s3;
	logic             en1, en2, en3, accept;
	qpim_pkg::s1_t    stg_s1, s1_c;
	qpim_pkg::s2_t    stg_s2, s2_c;
	qpim_pkg::rsp_t   rsp_s3, rsp_c;

	logic [LVL_W-1:0] dec_lvl;
	logic [IDX_W-1:0] rd_noff, rd_poff;
	logic [LOG_W-1:0] p2_gl, p2_s;
	logic             p2_hc;
	logic [IDX_W-1:0] lpi, dlni, dz_full, lni_mask;
	logic [LNI_W-1:0] e_lni;
	logic             e_bad;

	logic [SUM_W-1:0] node_sum, patch_sum, enc_patch, lni_scaled;
	logic             err3;
	logic [GRID_W-1:0] g_full, g_half;
	logic [ORG_W-1:0] ox, oz;

	function automatic logic [IDX_W-1:0] sat_idx(input logic [ACC_W-1:0] v);
		sat_idx = (v > ACC_W'(qpim_pkg::SAT24)) ? qpim_pkg::SAT24 : v[IDX_W-1:0];
	endfunction

	// ---------------- configuration ----------------
	assign cfg_hit = cfg_we && (cfg_index inside {qpim_pkg::CFG_TILE_LOG2,
		qpim_pkg::CFG_PATCH_QUADS, qpim_pkg::CFG_LEVEL_LIMIT});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_log2_q   <= qpim_pkg::RST_TILE_LOG2;
			patch_quads_q <= qpim_pkg::RST_PATCH_QUADS;
			level_limit_q <= qpim_pkg::RST_LEVEL_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				qpim_pkg::CFG_TILE_LOG2:   tile_log2_q   <= cfg_data[LOG_W-1:0];
				qpim_pkg::CFG_PATCH_QUADS: patch_quads_q <= cfg_data;
				qpim_pkg::CFG_LEVEL_LIMIT: level_limit_q <= cfg_data[LVL_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp registers into tile log2, patch log2 and level count
	always_comb begin
		tlog_c = tile_log2_q;
		if (tlog_c < LOG_W'(1))
			tlog_c = LOG_W'(1);
		if (tlog_c > LOG_W'(MAX_TILE_LOG2))
			tlog_c = LOG_W'(MAX_TILE_LOG2);
		pq_c = (patch_quads_q < PQ_W'(2)) ? PQ_W'(2) : patch_quads_q;
		plog_c = '0;
		for (int i = 1; i < PQ_W; i++) begin
			if (pq_c[i])
				plog_c = LOG_W'(i);
		end
		if (plog_c > tlog_c)
			plog_c = tlog_c;
		lim_c = {1'b0, level_limit_q};
		if (lim_c < CNT_W'(1))
			lim_c = CNT_W'(1);
		if (lim_c > CNT_W'(MAX_LEVELS))
			lim_c = CNT_W'(MAX_LEVELS);
		lcnt_c = (lim_c < {1'b0, tlog_c}) ? lim_c : {1'b0, tlog_c};
	end

	// ---------------- table sweep ----------------
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			qpim_pkg::DRV_IDLE: state_nxt = qpim_pkg::DRV_IDLE;
			qpim_pkg::DRV_INIT: state_nxt = qpim_pkg::DRV_RUN;
			qpim_pkg::DRV_RUN: begin
				if (sweep_q == LVL_W'(MAX_LEVELS - 1))
					state_nxt = qpim_pkg::DRV_IDLE;
			end
			default: state_nxt = qpim_pkg::DRV_IDLE;
		endcase
		// restart on any register write
		if (cfg_hit)
			state_nxt = qpim_pkg::DRV_INIT;
	end

	always_comb begin
		busy       = 1'b0;
		init_en    = 1'b0;
		run_en     = 1'b0;
		sweep_last = 1'b0;
		case (state_q)
			qpim_pkg::DRV_IDLE: ;
			qpim_pkg::DRV_INIT: begin
				busy    = 1'b1;
				init_en = 1'b1;
			end
			qpim_pkg::DRV_RUN: begin
				busy       = 1'b1;
				run_en     = 1'b1;
				sweep_last = (sweep_q == LVL_W'(MAX_LEVELS - 1));
			end
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qpim_pkg::DRV_INIT;
			sweep_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (init_en)
				sweep_q <= '0;
			else if (run_en && !sweep_last)
				sweep_q <= sweep_q + LVL_W'(1);
		end
	end

	always_comb begin
		sw_gl   = qpim_pkg::grid_log(plog_q, tlog_q, sweep_q);
		sw_s    = tlog_q - sw_gl;
		sw_hc   = qpim_pkg::has_children(plog_q, tlog_q, sweep_q);
		sw_cnt  = ACC_W'(1) << {sw_s, 1'b0};
		sw_pcnt = sw_hc ? (sw_cnt << 2) : sw_cnt;
		sw_act  = ({1'b0, sweep_q} < lcnt_q);
		noff_nxt = noff_acc_q + (sw_act ? sw_cnt : '0);
		poff_nxt = poff_acc_q + (sw_act ? sw_pcnt : '0);
	end

	always_ff @(posedge clk) begin
		if (init_en) begin
			tlog_q     <= tlog_c;
			plog_q     <= plog_c;
			lcnt_q     <= lcnt_c;
			noff_acc_q <= '0;
			poff_acc_q <= '0;
		end else if (run_en) begin
			for (int i = 0; i < MAX_LEVELS; i++) begin
				if (sweep_q == LVL_W'(i)) begin
					noff_tab_q[i] <= sw_act ? sat_idx(noff_acc_q) : '0;
					poff_tab_q[i] <= sw_act ? sat_idx(poff_acc_q) : '0;
				end
			end
			noff_acc_q <= noff_nxt;
			poff_acc_q <= poff_nxt;
			if (sweep_last)
				ptot_q <= sat_idx(poff_nxt);
		end
	end

	// ---------------- pipeline control ----------------
	assign en3       = !v_s3 || !rsp_stall;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign req_stall = busy || !en1;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= accept;
			if (en2)
				v_s2 <= v_s1;
			if (en3)
				v_s3 <= v_s2;
		end
	end

	// ---------------- stage 1: level search ----------------
	always_comb begin
		dec_lvl = '0;
		// offsets rise with level, so the passing levels form a prefix
		for (int i = 1; i < MAX_LEVELS; i++) begin
			if (CNT_W'(i) < lcnt_q && poff_tab_q[i] <= index_in)
				dec_lvl = dec_lvl + LVL_W'(1);
		end
		s1_c.req = qpim_pkg::req_t'(req_type);
		s1_c.idx = index_in;
		s1_c.x   = key_x;
		s1_c.z   = key_z;
		s1_c.q   = key_quadrant;
		if (s1_c.req == qpim_pkg::REQ_DECODE) begin
			s1_c.lvl = dec_lvl;
			s1_c.err = (index_in >= ptot_q);
		end else begin
			s1_c.lvl = key_level;
			s1_c.err = ({1'b0, key_level} >= lcnt_q);
		end
	end

	always_ff @(posedge clk) begin
		if (en1)
			stg_s1 <= s1_c;
	end

	// ---------------- stage 2: table read, unpack or pack ----------------
	always_comb begin
		rd_noff = '0;
		rd_poff = '0;
		for (int i = 0; i < MAX_LEVELS; i++) begin
			if (stg_s1.lvl == LVL_W'(i)) begin
				rd_noff = noff_tab_q[i];
				rd_poff = poff_tab_q[i];
			end
		end
		p2_gl = qpim_pkg::grid_log(plog_q, tlog_q, stg_s1.lvl);
		p2_s  = tlog_q - p2_gl;
		p2_hc = qpim_pkg::has_children(plog_q, tlog_q, stg_s1.lvl);

		// decode: split the level-local patch index
		lpi      = stg_s1.idx - rd_poff;
		dlni     = p2_hc ? (lpi >> 2) : lpi;
		lni_mask = (IDX_W'(1) << p2_s) - IDX_W'(1);
		dz_full  = dlni >> p2_s;

		// encode: range check and row-major node index
		e_bad = ((stg_s1.x >> p2_s) != '0) || ((stg_s1.z >> p2_s) != '0)
			|| (!p2_hc && stg_s1.q != '0);
		e_lni = (LNI_W'(stg_s1.z) << p2_s) | LNI_W'(stg_s1.x);

		s2_c.req  = stg_s1.req;
		s2_c.idx  = stg_s1.idx;
		s2_c.lvl  = stg_s1.lvl;
		s2_c.noff = rd_noff;
		s2_c.poff = rd_poff;
		s2_c.hc   = p2_hc;
		s2_c.gl   = p2_gl;
		if (stg_s1.req == qpim_pkg::REQ_DECODE) begin
			s2_c.x   = dlni[XZ_W-1:0] & lni_mask[XZ_W-1:0];
			s2_c.z   = dz_full[XZ_W-1:0];
			s2_c.q   = p2_hc ? lpi[1:0] : '0;
			s2_c.lni = LNI_W'(dlni);
			s2_c.err = stg_s1.err;
		end else begin
			s2_c.x   = stg_s1.x;
			s2_c.z   = stg_s1.z;
			s2_c.q   = stg_s1.q;
			s2_c.lni = e_lni;
			s2_c.err = stg_s1.err || e_bad;
		end
	end

	always_ff @(posedge clk) begin
		if (en2)
			stg_s2 <= s2_c;
	end

	// ---------------- stage 3: index sums, region, output ----------------
	always_comb begin
		node_sum   = SUM_W'(stg_s2.noff) + SUM_W'(stg_s2.lni);
		lni_scaled = stg_s2.hc ? SUM_W'({stg_s2.lni, 2'b00}) : SUM_W'(stg_s2.lni);
		enc_patch  = SUM_W'(stg_s2.poff) + lni_scaled + SUM_W'(stg_s2.q);
		patch_sum  = (stg_s2.req == qpim_pkg::REQ_DECODE) ? SUM_W'(stg_s2.idx) : enc_patch;
		err3 = stg_s2.err
			|| (stg_s2.noff >= qpim_pkg::SAT24)
			|| (node_sum >= SUM_W'(qpim_pkg::SAT24))
			|| (patch_sum >= SUM_W'(qpim_pkg::SAT24))
			|| (stg_s2.req == qpim_pkg::REQ_ENCODE && stg_s2.poff >= qpim_pkg::SAT24);

		g_full = GRID_W'(1) << stg_s2.gl;
		g_half = g_full >> 1;
		ox = {1'b0, stg_s2.x} << stg_s2.gl;
		oz = {1'b0, stg_s2.z} << stg_s2.gl;
		if (stg_s2.hc) begin
			ox = ox + (stg_s2.q[0] ? g_half[ORG_W-1:0] : '0);
			oz = oz + (stg_s2.q[1] ? g_half[ORG_W-1:0] : '0);
		end

		rsp_c = '0;
		if (err3) begin
			rsp_c.error = 1'b1;
		end else begin
			rsp_c.node_level   = stg_s2.lvl;
			rsp_c.node_x       = stg_s2.x;
			rsp_c.node_z       = stg_s2.z;
			rsp_c.quadrant     = stg_s2.q;
			rsp_c.node_index   = node_sum[IDX_W-1:0];
			rsp_c.patch_index  = patch_sum[IDX_W-1:0];
			rsp_c.origin_x     = ox;
			rsp_c.origin_z     = oz;
			rsp_c.region_quads = stg_s2.hc ? g_half[RGN_W-1:0] : g_full[RGN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en3)
			rsp_s3 <= rsp_c;
	end

	assign rsp_valid    = v_s3;
	assign error        = rsp_s3.error;
	assign node_level   = rsp_s3.node_level;
	assign node_x       = rsp_s3.node_x;
	assign node_z       = rsp_s3.node_z;
	assign quadrant     = rsp_s3.quadrant;
	assign node_index   = rsp_s3.node_index;
	assign patch_index  = rsp_s3.patch_index;
	assign origin_x     = rsp_s3.origin_x;
	assign origin_z     = rsp_s3.origin_z;
	assign region_quads = rsp_s3.region_quads;

	// ---------------- assertions ----------------
	`QPIM_ASSERT_NEXT(a_cfg_blocks_req, clk, arst_n, cfg_hit, req_stall, "item taken during table rebuild")
	`QPIM_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, accept, v_s1, "accepted item missing from stage 1")
	`QPIM_ASSERT_NEXT(a_s2_hold, clk, arst_n, v_s2 && !en3, v_s2, "stage 2 item lost under stall")
	`QPIM_ASSERT_IMPLY(a_err_clean, clk, arst_n, rsp_valid && error, node_index == '0 && patch_index == '0 && region_quads == '0 && node_level == '0, "error result carries data")

endmodule
